// File: hw/rtl/rotenc_pkg.sv
// ----------------------------------------------------------------------------
// rotenc_pkg
// Shared types and constants for the rotary encoder event generator.
// ----------------------------------------------------------------------------
package rotenc_pkg;

  // input kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_PRESS   = 3'd1;
  localparam logic [2:0] KIND_RELEASE = 3'd2;
  localparam logic [2:0] KIND_ENABLE  = 3'd3;
  localparam logic [2:0] KIND_DISABLE = 3'd4;

  // event types
  localparam logic [1:0] EVT_ROTATION = 2'd0;
  localparam logic [1:0] EVT_CLICK    = 2'd1;
  localparam logic [1:0] EVT_LONG     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [1:0] CFG_POLL       = 2'd2;

  localparam logic [9:0]  DEBOUNCE_RST   = 10'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [9:0]  POLL_RST       = 10'd10;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         event_type;
    logic signed [14:0] step_delta;
    logic               last_result;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: hw/rtl/rotenc_core.sv
// ----------------------------------------------------------------------------
// rotenc_core
// Input register, configuration registers and event state; produces up to
// two results per transaction.
// ----------------------------------------------------------------------------
module rotenc_core import rotenc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_accept,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_counter_value,
  input  logic        in_switch_pressed,
  input  logic        in_pin_is_switch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output push_t       push
);

  logic        stg_valid_r;
  logic [2:0]  kind_r;
  logic [15:0] counter_r;
  logic        held_r;
  logic        on_switch_r;

  logic [9:0]  debounce_r;
  logic [15:0] long_press_r;
  logic [9:0]  poll_r;

  logic [31:0] time_r, time_nxt;
  logic [31:0] last_edge_r, last_edge_nxt;
  logic [15:0] ref_r, ref_nxt;
  logic        token_r, token_nxt;
  logic        lp_run_r, lp_run_nxt;
  logic [15:0] lp_rem_r, lp_rem_nxt;
  logic        rot_en_r, rot_en_nxt;
  logic [9:0]  poll_rem_r, poll_rem_nxt;

  logic [15:0]        diff;
  logic [15:0]        biased;
  logic signed [14:0] steps;
  logic               edge_ok;
  logic               rot_hit;
  logic               long_hit;
  logic               click_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= in_accept;
    end
    if (in_accept) begin
      kind_r      <= in_kind;
      counter_r   <= in_counter_value;
      held_r      <= in_switch_pressed;
      on_switch_r <= in_pin_is_switch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      poll_r       <= POLL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_data[9:0];
        CFG_LONG_PRESS: long_press_r <= cfg_data;
        CFG_POLL:       poll_r       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // signed change halved toward zero
  assign diff   = counter_r - ref_r;
  assign biased = diff + {15'd0, diff[15]};
  assign steps  = biased[15:1];
  assign edge_ok = on_switch_r && ((time_r - last_edge_r) >= {22'd0, debounce_r});

  always_comb begin
    time_nxt      = time_r;
    last_edge_nxt = last_edge_r;
    ref_nxt       = ref_r;
    token_nxt     = token_r;
    lp_run_nxt    = lp_run_r;
    lp_rem_nxt    = lp_rem_r;
    rot_en_nxt    = rot_en_r;
    poll_rem_nxt  = poll_rem_r;
    rot_hit       = 1'b0;
    long_hit      = 1'b0;
    click_hit     = 1'b0;
    if (stg_valid_r) begin
      case (kind_r)
        KIND_TICK: begin
          time_nxt = time_r + 32'd1;
          if (rot_en_r) begin
            if (poll_rem_r <= 10'd1) begin
              poll_rem_nxt = poll_r;
              if (steps != 15'sd0) begin
                rot_hit = 1'b1;
                ref_nxt = ref_r + {steps, 1'b0};
              end
            end else begin
              poll_rem_nxt = poll_rem_r - 10'd1;
            end
          end
          if (lp_run_r) begin
            if (lp_rem_r <= 16'd1) begin
              lp_run_nxt = 1'b0;
              lp_rem_nxt = 16'd0;
              if (token_r) begin
                token_nxt = 1'b0;
                long_hit  = held_r;
              end
            end else begin
              lp_rem_nxt = lp_rem_r - 16'd1;
            end
          end
        end
        KIND_PRESS: begin
          if (edge_ok) begin
            last_edge_nxt = time_r;
            token_nxt     = 1'b1;
            lp_run_nxt    = 1'b1;
            lp_rem_nxt    = long_press_r;
          end
        end
        KIND_RELEASE: begin
          if (edge_ok) begin
            last_edge_nxt = time_r;
            if (token_r) begin
              token_nxt  = 1'b0;
              lp_run_nxt = 1'b0;
              lp_rem_nxt = 16'd0;
              click_hit  = 1'b1;
            end
          end
        end
        KIND_ENABLE: begin
          rot_en_nxt   = 1'b1;
          poll_rem_nxt = poll_r;
          ref_nxt      = counter_r;
        end
        KIND_DISABLE: begin
          rot_en_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      last_edge_r <= '0;
      ref_r       <= '0;
      token_r     <= 1'b0;
      lp_run_r    <= 1'b0;
      lp_rem_r    <= '0;
      rot_en_r    <= 1'b0;
      poll_rem_r  <= '0;
    end else begin
      time_r      <= time_nxt;
      last_edge_r <= last_edge_nxt;
      ref_r       <= ref_nxt;
      token_r     <= token_nxt;
      lp_run_r    <= lp_run_nxt;
      lp_rem_r    <= lp_rem_nxt;
      rot_en_r    <= rot_en_nxt;
      poll_rem_r  <= poll_rem_nxt;
    end
  end

  // rotation goes first when both fire
  always_comb begin
    push.num = {1'b0, rot_hit} + {1'b0, long_hit} + {1'b0, click_hit};
    push.r0  = '0;
    push.r1  = '0;
    if (rot_hit) begin
      push.r0.event_type  = EVT_ROTATION;
      push.r0.step_delta  = steps;
      push.r0.last_result = !long_hit;
      push.r1.event_type  = EVT_LONG;
      push.r1.last_result = 1'b1;
    end else if (long_hit) begin
      push.r0.event_type  = EVT_LONG;
      push.r0.last_result = 1'b1;
    end else begin
      push.r0.event_type  = EVT_CLICK;
      push.r0.last_result = 1'b1;
    end
  end

endmodule

// File: hw/rtl/rotenc_outq.sv
// ----------------------------------------------------------------------------
// rotenc_outq
// Result queue: takes up to two results per cycle, hands out one per
// transaction.
// ----------------------------------------------------------------------------
module rotenc_outq import rotenc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  output logic [OQ_CW-1:0] count,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res
);

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] count_r;
  logic             pop;
  logic [OQ_AW-1:0] wr_ptr_p1;

  assign pop       = (count_r != '0) && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + OQ_AW'(1);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_AW'(push.num);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      end
      count_r <= count_r + OQ_CW'(push.num) - OQ_CW'(pop);
    end
  end

  assign count     = count_r;
  assign out_valid = (count_r != '0);
  assign out_res   = mem[rd_ptr_r];

endmodule

// File: hw/rtl/rotary_encoder_event_generator.sv
// ----------------------------------------------------------------------------
// rotary_encoder_event_generator
// Rotation, click and long-press events from 1 ms ticks and switch edges.
//
//   channel  ports                                              direction
//   in       in_valid/in_ready, in_kind, in_counter_value,      sink
//            in_switch_pressed, in_pin_is_switch
//   out      out_valid/out_ready, out_event_type,               source
//            out_step_delta, out_last_result
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data           sink
//
// one input transaction per cycle while in_ready is high; accepted items pass
// the core's input register and then a four-entry result queue, and results
// leave one per cycle while out_ready is high; in_ready drops when the queue
// cannot take two more results beyond those already on their way; cfg_ready
// is always high; synchronous active-low reset clears control state and loads register defaults
// ----------------------------------------------------------------------------
module rotary_encoder_event_generator import rotenc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [15:0]        in_counter_value,
  input  logic               in_switch_pressed,
  input  logic               in_pin_is_switch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_type,
  output logic signed [14:0] out_step_delta,
  output logic               out_last_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  push_t            push;
  res_t             out_res;
  logic [OQ_CW-1:0] count;
  logic [OQ_CW:0]   need;
  logic             in_accept;

  assign need      = {1'b0, count} + (OQ_CW + 1)'(push.num) + (OQ_CW + 1)'(2);
  assign in_ready  = (need <= (OQ_CW + 1)'(OQ_DEPTH));
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rotenc_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .in_kind           (in_kind),
    .in_counter_value  (in_counter_value),
    .in_switch_pressed (in_switch_pressed),
    .in_pin_is_switch  (in_pin_is_switch),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push)
  );

  rotenc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .count     (count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_type  = out_res.event_type;
  assign out_step_delta  = out_res.step_delta;
  assign out_last_result = out_res.last_result;

endmodule

// File: hw/rtl/rotenc_checker.sv
// ----------------------------------------------------------------------------
// rotenc_checker
// Port-level checks on the result channel of the event generator.
// ----------------------------------------------------------------------------
module rotenc_checker import rotenc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_event_type,
  input logic signed [14:0] out_step_delta,
  input logic              out_last_result
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_type)
      && $stable(out_step_delta) && $stable(out_last_result))
    else $error("result changed while stalled");

  // only rotation carries steps, and never zero
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_type == EVT_ROTATION) == (out_step_delta != 15'sd0)))
    else $error("step field inconsistent with event type");

  a_click_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_type == EVT_CLICK |-> out_last_result)
    else $error("click not the last result");

  // a rotation that is not last is followed right away by a long press
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_event_type == EVT_ROTATION && !out_last_result
      |=> out_valid && out_event_type == EVT_LONG && out_last_result)
    else $error("rotation pair broken");

endmodule

bind rotary_encoder_event_generator rotenc_checker u_rotenc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_type  (out_event_type),
  .out_step_delta  (out_step_delta),
  .out_last_result (out_last_result)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the rotary encoder event generator against a cycle-free predictor of
// its rotation, click and long-press behavior. Directed tests cover reset
// defaults, step extremes, debounce boundaries, both events on one tick and
// the longest intervals; random phases follow with fresh register settings.
// Both channels idle and stall at random; every result is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import rotenc_pkg::*;

  localparam logic [2:0] KIND_LAST = 3'd7;
  localparam int COUNTS_PER_DETENT = 2;
  localparam int SETTLE_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS = 125;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_kind = KIND_TICK;
  logic [15:0]        in_counter_value = '0;
  logic               in_switch_pressed = 1'b0;
  logic               in_pin_is_switch = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_event_type;
  logic signed [14:0] out_step_delta;
  logic               out_last_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_DEBOUNCE;
  logic [15:0]        cfg_data = '0;

  rotary_encoder_event_generator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_counter_value  (in_counter_value),
    .in_switch_pressed (in_switch_pressed),
    .in_pin_is_switch  (in_pin_is_switch),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_type    (out_event_type),
    .out_step_delta    (out_step_delta),
    .out_last_result   (out_last_result),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [9:0]  debounce_ticks;
  logic [15:0] long_press_ticks;
  logic [9:0]  poll_ticks;
  logic [31:0] time_now;
  logic [31:0] last_edge_time;
  logic [15:0] reference_count;
  logic        press_token;
  logic        long_press_running;
  logic [15:0] long_press_left;
  logic        rotation_on;
  logic [9:0]  poll_left;

  res_t expected_events[$];
  res_t want;

  int error_count = 0;
  int items_sent = 0;
  int rotations_seen = 0;
  int clicks_seen = 0;
  int long_presses_seen = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [15:0] knob_count = '0;
  logic        switch_held = 1'b0;

  function automatic void reset_model();
    debounce_ticks     = DEBOUNCE_RST;
    long_press_ticks   = LONG_PRESS_RST;
    poll_ticks         = POLL_RST;
    time_now           = '0;
    last_edge_time     = '0;
    reference_count    = '0;
    press_token        = 1'b0;
    long_press_running = 1'b0;
    long_press_left    = '0;
    rotation_on        = 1'b0;
    poll_left          = '0;
  endfunction

  function automatic logic edge_passes_debounce();
    logic [31:0] since;
    since = time_now - last_edge_time;
    if (since < 32'(debounce_ticks)) return 1'b0;
    last_edge_time = time_now;
    return 1'b1;
  endfunction

  function automatic void predict_events(input logic [2:0] kind, input logic [15:0] count,
                                         input logic held, input logic on_switch);
    res_t found[2];
    int n;
    logic [15:0] diff;
    int signed_diff;
    int steps;
    n = 0;
    case (kind)
      KIND_TICK: begin
        time_now = time_now + 32'd1;
        if (rotation_on) begin
          if (poll_left <= 1) begin
            diff = count - reference_count;
            signed_diff = $signed(diff);
            steps = signed_diff / COUNTS_PER_DETENT;
            poll_left = poll_ticks;
            if (steps != 0) begin
              found[n] = '{event_type: EVT_ROTATION, step_delta: 15'(steps), last_result: 1'b0};
              n++;
              reference_count = reference_count + 16'(steps * COUNTS_PER_DETENT);
            end
          end else begin
            poll_left = poll_left - 10'd1;
          end
        end
        if (long_press_running) begin
          if (long_press_left <= 1) begin
            long_press_running = 1'b0;
            long_press_left = '0;
            if (press_token) begin
              press_token = 1'b0;
              if (held) begin
                found[n] = '{event_type: EVT_LONG, step_delta: '0, last_result: 1'b0};
                n++;
              end
            end
          end else begin
            long_press_left = long_press_left - 16'd1;
          end
        end
      end
      KIND_PRESS: begin
        if (on_switch && edge_passes_debounce()) begin
          press_token = 1'b1;
          long_press_running = 1'b1;
          long_press_left = long_press_ticks;
        end
      end
      KIND_RELEASE: begin
        if (on_switch && edge_passes_debounce() && press_token) begin
          press_token = 1'b0;
          long_press_running = 1'b0;
          long_press_left = '0;
          found[n] = '{event_type: EVT_CLICK, step_delta: '0, last_result: 1'b0};
          n++;
        end
      end
      KIND_ENABLE: begin
        rotation_on = 1'b1;
        poll_left = poll_ticks;
        reference_count = count;
      end
      KIND_DISABLE: rotation_on = 1'b0;
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      found[i].last_result = (i == n - 1);
      expected_events.push_back(found[i]);
    end
  endfunction

  task automatic send_item(input logic [2:0] kind, input logic [15:0] count,
                           input logic held, input logic on_switch);
    logic accepted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_counter_value  <= count;
    in_switch_pressed <= held;
    in_pin_is_switch  <= on_switch;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = in_ready;
      @(posedge clk);
    end
    predict_events(kind, count, held, on_switch);
    items_sent++;
  endtask

  task automatic tick(input logic [15:0] count, input logic held);
    send_item(KIND_TICK, count, held, 1'($urandom_range(0, 1)));
  endtask

  task automatic switch_edge(input logic [2:0] kind, input logic on_switch);
    send_item(kind, 16'($urandom), 1'($urandom_range(0, 1)), on_switch);
  endtask

  // hold off until every expected result is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    logic accepted;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (index)
      CFG_DEBOUNCE:   debounce_ticks = value[9:0];
      CFG_LONG_PRESS: long_press_ticks = value;
      CFG_POLL:       poll_ticks = value[9:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int debounce, input int long_press, input int poll);
    settle();
    write_register(CFG_DEBOUNCE, 16'(debounce));
    write_register(CFG_LONG_PRESS, 16'(long_press));
    write_register(CFG_POLL, 16'(poll));
  endtask

  task automatic test_reset_defaults();
    // edges right after reset fall inside the default debounce window
    switch_edge(KIND_PRESS, 1'b1);
    switch_edge(KIND_RELEASE, 1'b1);
    for (int k = int'(KIND_DISABLE) + 1; k <= int'(KIND_LAST); k++)
      send_item(3'(k), 16'hFFFF, 1'b1, 1'b1);
    send_item(KIND_ENABLE, 16'h0010, 1'b0, 1'b0);
    repeat (POLL_RST) tick(16'h0015, 1'b0);
    send_item(KIND_DISABLE, 16'h0000, 1'b0, 1'b0);
    send_item(KIND_DISABLE, 16'h0000, 1'b0, 1'b0);
  endtask

  task automatic test_rotation_extremes();
    configure(DEBOUNCE_RST, LONG_PRESS_RST, 1);
    send_item(KIND_ENABLE, 16'h0000, 1'b0, 1'b0);
    tick(16'h7FFF, 1'b0);
    tick(16'hFFFE, 1'b0);
    tick(16'hFFFD, 1'b0);
    tick(16'hFFFB, 1'b0);
    tick(16'hFFFD, 1'b0);
    tick(16'h0000, 1'b0);
    send_item(KIND_ENABLE, 16'h1234, 1'b0, 1'b0);
    tick(16'h1234, 1'b0);
    send_item(KIND_DISABLE, 16'h0000, 1'b0, 1'b0);
    tick(16'h5555, 1'b0);
  endtask

  task automatic test_button_events();
    configure(2, 3, 1);
    repeat (3) tick(16'h0000, 1'b0);
    switch_edge(KIND_PRESS, 1'b1);
    tick(16'h0000, 1'b1);
    switch_edge(KIND_RELEASE, 1'b0);
    switch_edge(KIND_RELEASE, 1'b1);
    tick(16'h0000, 1'b1);
    switch_edge(KIND_RELEASE, 1'b1);
    repeat (2) tick(16'h0000, 1'b0);
    switch_edge(KIND_PRESS, 1'b1);
    repeat (3) tick(16'h0000, 1'b1);
    repeat (2) tick(16'h0000, 1'b0);
    switch_edge(KIND_RELEASE, 1'b1);
    repeat (2) tick(16'h0000, 1'b0);
    switch_edge(KIND_PRESS, 1'b1);
    repeat (3) tick(16'h0000, 1'b0);
    switch_edge(KIND_PRESS, 1'b0);
    repeat (2) tick(16'h0000, 1'b0);
    switch_edge(KIND_RELEASE, 1'b1);
  endtask

  task automatic test_rotation_with_long_press();
    configure(0, 1, 1);
    send_item(KIND_ENABLE, 16'h0000, 1'b0, 1'b0);
    switch_edge(KIND_PRESS, 1'b1);
    tick(16'h0004, 1'b1);
    switch_edge(KIND_PRESS, 1'b1);
    switch_edge(KIND_RELEASE, 1'b1);
    send_item(KIND_DISABLE, 16'h0000, 1'b0, 1'b0);
  endtask

  task automatic test_longest_intervals();
    configure(0, 65535, 1000);
    send_item(KIND_ENABLE, 16'h0000, 1'b0, 1'b0);
    switch_edge(KIND_PRESS, 1'b1);
    for (int i = 1; i <= 200; i++) tick(16'(i * 37), 1'b1);
    switch_edge(KIND_RELEASE, 1'b1);
    configure(1000, 65535, 1000);
    switch_edge(KIND_PRESS, 1'b1);
    tick(16'h0000, 1'b1);
    switch_edge(KIND_RELEASE, 1'b1);
    send_item(KIND_DISABLE, 16'h0000, 1'b0, 1'b0);
  endtask

  task automatic random_item();
    int pick;
    logic on_switch;
    pick = $urandom_range(0, 99);
    on_switch = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 24) == 0) knob_count = 16'($urandom);
    else knob_count = knob_count + 16'($urandom_range(0, 6)) - 16'd3;
    if (pick < 60) begin
      tick(knob_count, ($urandom_range(0, 15) == 0) ? !switch_held : switch_held);
    end else if (pick < 72) begin
      if (on_switch) switch_held = 1'b1;
      switch_edge(KIND_PRESS, on_switch);
    end else if (pick < 84) begin
      if (on_switch) switch_held = 1'b0;
      switch_edge(KIND_RELEASE, on_switch);
    end else if (pick < 89) begin
      send_item(KIND_ENABLE, knob_count, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 93) begin
      send_item(KIND_DISABLE, 16'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end else begin
      send_item(3'($urandom_range(int'(KIND_DISABLE) + 1, int'(KIND_LAST))), 16'($urandom),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_traffic();
    int debounce;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0: debounce = 0;
        1: debounce = 1;
        default: debounce = $urandom_range(2, 6);
      endcase
      configure(debounce, ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 30),
                $urandom_range(1, 8));
      send_item(KIND_ENABLE, knob_count, 1'b0, 1'b0);
      repeat (PHASE_ITEMS) random_item();
    end
  endtask

  // result checker
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t unexpected result: type %0d delta %0d last %0b", $time,
                 out_event_type, out_step_delta, out_last_result);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_event_type !== want.event_type) begin
          $display("%0t event_type mismatch: expected %0d actual %0d", $time,
                   want.event_type, out_event_type);
          error_count++;
        end
        if (out_step_delta !== want.step_delta) begin
          $display("%0t step_delta mismatch: expected %0d actual %0d", $time,
                   want.step_delta, out_step_delta);
          error_count++;
        end
        if (out_last_result !== want.last_result) begin
          $display("%0t last_result mismatch: expected %0b actual %0b", $time,
                   want.last_result, out_last_result);
          error_count++;
        end
        case (out_event_type)
          EVT_ROTATION: rotations_seen++;
          EVT_CLICK:    clicks_seen++;
          EVT_LONG:     long_presses_seen++;
          default: ;
        endcase
      end
    end
  end

  // result receiver with changing stall patterns
  int rx_cycle = 0;
  int rx_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 3);
    if (rx_mode == 3) begin
      out_ready <= (rx_cycle % 4 == 0);
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 2) == 0) stall_left <= $urandom_range(1, 3);
      if (rx_mode == 2 && $urandom_range(0, 1) == 0) stall_left <= $urandom_range(1, 20);
    end
  end

  // worst legal quiet stretch is a sender gap plus a long stall, far below the limit
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles, %0d results pending", $time,
               idle_cycles, expected_events.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_rotation_extremes();
    test_button_events();
    test_rotation_with_long_press();
    test_longest_intervals();
    test_random_traffic();
    settle();
    $display("sent %0d input transactions; checked %0d rotations, %0d clicks, %0d long presses",
             items_sent, rotations_seen, clicks_seen, long_presses_seen);
    $display("register settings ran from the smallest to the largest intervals");
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
